// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared request/result types, operation and status codes, and the command
// group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Operation codes
  localparam logic [2:0] FUNC_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK   = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT   = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK    = 3'd3;
  localparam logic [2:0] FUNC_WRITE_FRONT = 3'd4;
  localparam logic [2:0] FUNC_WRITE_BACK  = 3'd5;

  // Status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [8:0]         count_after;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch the incoming request
    logic pop_read;   // read the entry that a pop removes
    logic exec;       // update store, front position and count
    logic capture;    // form the result register
  } cmd_t;

endpackage

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two with registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== rtl/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for one request: pop read, execute, end-word read, capture,
// then present the result until it is taken.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output deq_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_EXEC,
    S_VIEW_RD,
    S_CAPTURE,
    S_SEND
  } state_t;

  state_t state;
  logic   accept;

  assign accept = req_valid && !req_stall;

  // Advance the sequence; hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_stall <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state     <= S_POP_RD;
            req_stall <= 1'b1;
          end
        end
        S_POP_RD:  state <= S_EXEC;
        S_EXEC:    state <= S_VIEW_RD;
        S_VIEW_RD: state <= S_CAPTURE;
        S_CAPTURE: begin
          state     <= S_SEND;
          rsp_valid <= 1'b1;
        end
        S_SEND: begin
          if (!rsp_stall) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b0;
            req_stall <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Decode commands for the datapath
  always_comb begin
    cmd.load     = accept;
    cmd.pop_read = (state == S_POP_RD);
    cmd.exec     = (state == S_EXEC);
    cmd.capture  = (state == S_CAPTURE);
  end

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request channel open while a result is pending");

  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (req_stall && state == S_POP_RD))
    else $error("accepted request did not start the sequence");

  a_capture_shows_result: assert property (@(posedge clk) disable iff (rst)
    state == S_CAPTURE |=> rsp_valid)
    else $error("captured result not presented");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (!rsp_valid && !req_stall))
    else $error("idle with a pending result or closed request channel");
`endif

endmodule

// ===== rtl/deq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: request latch, front position and count, circular entry store,
// and the result register.
// ----------------------------------------------------------------------------
module deq_dp #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  deq_pkg::req_t  req,
  input  deq_pkg::cmd_t  cmd,
  output deq_pkg::rsp_t  rsp
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Request latch
  logic [2:0]           req_func;
  logic [31:0]          req_value;

  // Queue state
  logic [PW-1:0]        front_pos;
  logic [CW-1:0]        entry_count;

  // Per-request results
  logic [1:0]           status_r;
  logic [WORD_BITS-1:0] popped;

  logic [PW-1:0]        front_pos_next;
  logic [CW-1:0]        entry_count_next;
  logic [1:0]           status_next;
  logic [WORD_BITS-1:0] popped_next;

  logic [PW-1:0]        front_dec;
  logic [PW-1:0]        front_inc;
  logic [SW-1:0]        tail_sum;
  logic [SW-1:0]        last_sum;
  logic [PW-1:0]        tail_pos;
  logic [PW-1:0]        back_pos;
  logic                 is_empty;
  logic                 is_full;

  logic                 wr_en;
  logic [PW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [PW-1:0]        rd_addr_a;
  logic [WORD_BITS-1:0] rd_data_a;
  logic [WORD_BITS-1:0] rd_data_b;

  // Circular positions around the front
  always_comb begin
    front_dec = (front_pos == '0) ? PW'(DEPTH - 1) : front_pos - 1'b1;
    front_inc = (front_pos == PW'(DEPTH - 1)) ? '0 : front_pos + 1'b1;
    tail_sum  = SW'(front_pos) + SW'(entry_count);
    last_sum  = tail_sum - 1'b1;
    tail_pos  = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);
    if (entry_count == '0) begin
      back_pos = front_dec;
    end else begin
      back_pos = (last_sum >= SW'(DEPTH)) ? PW'(last_sum - SW'(DEPTH)) : PW'(last_sum);
    end
    is_empty  = (entry_count == '0);
    is_full   = (entry_count == CW'(DEPTH));
  end

  // Execute the request against the current state
  always_comb begin
    front_pos_next   = front_pos;
    entry_count_next = entry_count;
    status_next      = deq_pkg::STATUS_DONE;
    popped_next      = '0;
    wr_en            = 1'b0;
    wr_addr          = front_pos;
    wr_data          = WORD_BITS'(req_value);
    case (req_func) inside
      deq_pkg::FUNC_PUSH_FRONT: begin
        if (is_full) begin
          status_next = deq_pkg::STATUS_FULL;
        end else begin
          wr_en            = 1'b1;
          wr_addr          = front_dec;
          front_pos_next   = front_dec;
          entry_count_next = entry_count + 1'b1;
        end
      end
      deq_pkg::FUNC_PUSH_BACK: begin
        if (is_full) begin
          status_next = deq_pkg::STATUS_FULL;
        end else begin
          wr_en            = 1'b1;
          wr_addr          = tail_pos;
          entry_count_next = entry_count + 1'b1;
        end
      end
      deq_pkg::FUNC_POP_FRONT: begin
        if (is_empty) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          popped_next      = rd_data_a;
          front_pos_next   = front_inc;
          entry_count_next = entry_count - 1'b1;
        end
      end
      deq_pkg::FUNC_POP_BACK: begin
        if (is_empty) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          popped_next      = rd_data_a;
          entry_count_next = entry_count - 1'b1;
        end
      end
      deq_pkg::FUNC_WRITE_FRONT, deq_pkg::FUNC_WRITE_BACK: begin
        wr_en = 1'b1;
        if (is_empty) begin
          entry_count_next = CW'(1);
        end else if (req_func == deq_pkg::FUNC_WRITE_BACK) begin
          wr_addr = back_pos;
        end
      end
      default: ;
    endcase
    if (!cmd.exec) begin
      wr_en = 1'b0;
    end
  end

  // Read the entry a pop removes, otherwise the front entry
  always_comb begin
    if (cmd.pop_read && req_func == deq_pkg::FUNC_POP_BACK) begin
      rd_addr_a = back_pos;
    end else begin
      rd_addr_a = front_pos;
    end
  end

  deq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (back_pos),
    .rd_data_b (rd_data_b)
  );

  // Hold queue state; advance it on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      front_pos   <= '0;
      entry_count <= '0;
    end else if (cmd.exec) begin
      front_pos   <= front_pos_next;
      entry_count <= entry_count_next;
    end
  end

  // Latch the request and the per-request results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= req.func;
      req_value <= req.value;
    end
    if (cmd.exec) begin
      status_r <= status_next;
      popped   <= popped_next;
    end
    if (cmd.capture) begin
      rsp.status       <= status_r;
      rsp.popped_value <= 32'(popped);
      rsp.count_after  <= 9'(entry_count);
      rsp.front_value  <= is_empty ? '0 : 32'(rd_data_a);
      rsp.back_value   <= is_empty ? '0 : 32'(rd_data_b);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(front_pos) < SW'(DEPTH))
    else $error("front position beyond depth");

  a_state_only_on_exec: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> ($stable(entry_count) && $stable(front_pos)))
    else $error("queue state changed outside execute");
`endif

endmodule

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of words in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries an operation code
//   and a word: push or pop at either end, or overwrite either end word.
//   Result channel (rsp_valid / rsp_stall / rsp) returns one result per
//   request: status, popped word, new count, and new front and back words.
//   A request is taken at an edge where valid is high and stall is low.
//   After acceptance the request passes the pop read, execute, end-word
//   read and capture states; the next request waits until the result is taken.
//   This sequence comes from the store's registered read ports: one read for
//   the popped word before the update, one for the new end words after it.
//   req_stall stays high from acceptance until the result is taken; while
//   the receiver stalls, the result holds and no new request is taken.
//   Reset empties the queue (front position and count cleared); store
//   contents are not cleared and are only read inside the occupied span.
//   A pop on an empty queue reports empty, a push on a full one reports full;
//   an overwrite on an empty queue inserts the word as the only entry.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  deq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output deq_pkg::rsp_t  rsp
);

  deq_pkg::cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  deq_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule

// ===== tb/sv/deq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// Watches the request and result channels of the deque, keeps a shadow copy
// of the queue, predicts one result per accepted request and compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module deq_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  deq_pkg::req_t  req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  deq_pkg::rsp_t  rsp,
  output int             fail_count,
  output int             pending
);
  import deq_pkg::*;

  localparam int SLOTS      = 256;
  localparam int REPORT_CAP = 100;

  // Shadow queue: circular store, front slot and occupancy
  logic [31:0] slot_word [SLOTS];
  logic [7:0]  front_slot;
  logic [8:0]  held;

  rsp_t queued_outcomes [$];
  int   misses;

  task automatic report_miss(input string what);
    misses++;
    if (misses <= REPORT_CAP) begin
      $display("[%0t] deque mismatch: %s", $time, what);
    end
  endtask

  // Apply one request to the shadow queue and return the result it yields
  function automatic rsp_t deque_outcome(input req_t r);
    rsp_t       o;
    logic [7:0] back_slot;
    logic [7:0] tail_slot;
    o = '0;
    back_slot = front_slot + held[7:0] - 8'd1;
    tail_slot = front_slot + held[7:0];
    case (r.func)
      FUNC_PUSH_FRONT: begin
        if (held == SLOTS) begin
          o.status = STATUS_FULL;
        end else begin
          front_slot = front_slot - 8'd1;
          slot_word[front_slot] = r.value;
          held = held + 9'd1;
        end
      end
      FUNC_PUSH_BACK: begin
        if (held == SLOTS) begin
          o.status = STATUS_FULL;
        end else begin
          slot_word[tail_slot] = r.value;
          held = held + 9'd1;
        end
      end
      FUNC_POP_FRONT: begin
        if (held == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.popped_value = slot_word[front_slot];
          front_slot = front_slot + 8'd1;
          held = held - 9'd1;
        end
      end
      FUNC_POP_BACK: begin
        if (held == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.popped_value = slot_word[back_slot];
          held = held - 9'd1;
        end
      end
      FUNC_WRITE_FRONT, FUNC_WRITE_BACK: begin
        // an overwrite on an empty queue inserts the only entry
        if (held == 0) begin
          slot_word[front_slot] = r.value;
          held = 9'd1;
        end else if (r.func == FUNC_WRITE_FRONT) begin
          slot_word[front_slot] = r.value;
        end else begin
          slot_word[back_slot] = r.value;
        end
      end
      default: ;  // spare codes leave the queue alone
    endcase
    o.count_after = held;
    if (held != 0) begin
      back_slot = front_slot + held[7:0] - 8'd1;
      o.front_value = slot_word[front_slot];
      o.back_value  = slot_word[back_slot];
    end
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      front_slot = '0;
      held       = '0;
      misses     = 0;
      queued_outcomes.delete();
    end else begin
      // compare an accepted result with the oldest prediction
      if (rsp_valid && !rsp_stall) begin
        if (queued_outcomes.size() == 0) begin
          report_miss("result with no request outstanding");
        end else begin
          want = queued_outcomes.pop_front();
          if (rsp.status !== want.status)
            report_miss($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.popped_value !== want.popped_value)
            report_miss($sformatf("popped_value got %0d want %0d",
                                  rsp.popped_value, want.popped_value));
          if (rsp.count_after !== want.count_after)
            report_miss($sformatf("count_after got %0d want %0d",
                                  rsp.count_after, want.count_after));
          if (rsp.front_value !== want.front_value)
            report_miss($sformatf("front_value got %0d want %0d",
                                  rsp.front_value, want.front_value));
          if (rsp.back_value !== want.back_value)
            report_miss($sformatf("back_value got %0d want %0d",
                                  rsp.back_value, want.back_value));
        end
      end
      // predict the result of an accepted request
      if (req_valid && !req_stall) begin
        queued_outcomes.push_back(deque_outcome(req));
      end
    end
    fail_count <= misses;
    pending    <= queued_outcomes.size();
  end

endmodule

// ===== tb/sv/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives the deque with a short directed sequence (empty-queue pops and
// overwrites, extreme words, spare codes) and then fill, drain and churn
// mixes that reach both the full and the empty queue, under rotating phases
// of request gaps and result stalls. A separate checker scores the results.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int PHASE_LEN       = 120;
  localparam int TAIL_CYCLES     = 20;
  localparam int CYCLE_LIMIT     = 400000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_e;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;
  int cycles        = 0;
  int sent          = 0;
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;

  double_ended_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  deq_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at the current phase's rate
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one request, after optional idle cycles, and hold it until taken
  task automatic send_request(input logic [2:0] f, input logic signed [31:0] v);
    case ((sent / PHASE_LEN) % 4)
      0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
      default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req.func  <= f;
    req.value <= v;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  initial begin
    mix_e              mix;
    int                roll;
    logic [2:0]        f;
    logic signed [31:0] v;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-queue cases, extreme words, every code
    send_request(FUNC_POP_FRONT,   32'sd5);
    send_request(FUNC_POP_BACK,    32'sd6);
    send_request(FUNC_WRITE_FRONT, 32'sh7fff_ffff);
    send_request(FUNC_POP_BACK,    32'sd0);
    send_request(FUNC_WRITE_BACK,  32'sh8000_0000);
    send_request(FUNC_POP_FRONT,   32'sd0);
    send_request(FUNC_PUSH_FRONT,  32'sh8000_0000);
    send_request(FUNC_PUSH_BACK,   32'sh7fff_ffff);
    send_request(FUNC_PUSH_FRONT,  -32'sd1);
    send_request(FUNC_PUSH_BACK,   32'sd0);
    send_request(FUNC_WRITE_FRONT, 32'sh5555_5555);
    send_request(FUNC_WRITE_BACK,  32'shaaaa_aaaa);
    send_request(FUNC_SPARE_LO,    32'sd123);
    send_request(FUNC_SPARE_HI,    -32'sd123);
    send_request(FUNC_POP_BACK,    32'sd0);
    send_request(FUNC_POP_FRONT,   32'sd0);
    send_request(FUNC_POP_BACK,    32'sd0);
    send_request(FUNC_POP_FRONT,   32'sd0);
    send_request(FUNC_POP_FRONT,   32'sd0);
    send_request(FUNC_SPARE_HI,    32'sd0);

    // Random: long fill and drain runs reach full and empty, churn in between
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n < 420)       mix = MIX_FILL;
      else if (n < 840)  mix = MIX_DRAIN;
      else if (n < 1140) mix = MIX_CHURN;
      else if (n < 1560) mix = MIX_FILL;
      else               mix = MIX_DRAIN;

      roll = $urandom_range(99);
      case (mix)
        MIX_FILL:  roll = (roll < 75) ? 0 : (roll < 85) ? 1 : (roll < 95) ? 2 : 3;
        MIX_DRAIN: roll = (roll < 75) ? 1 : (roll < 85) ? 0 : (roll < 95) ? 2 : 3;
        default:   roll = (roll < 35) ? 0 : (roll < 70) ? 1 : (roll < 95) ? 2 : 3;
      endcase
      case (roll)
        0: f = $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
        1: f = $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
        2: f = $urandom_range(1) ? FUNC_WRITE_FRONT : FUNC_WRITE_BACK;
        default: f = $urandom_range(1) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
      endcase

      // mostly full-range words, sometimes the extremes
      case ($urandom_range(15))
        0: v = 32'sd0;
        1: v = -32'sd1;
        2: v = 32'sh8000_0000;
        3: v = 32'sh7fff_ffff;
        default: v = $urandom;
      endcase
      send_request(f, v);
    end
    req_valid <= 1'b0;

    // Let every outstanding result drain
    rsp_stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
